@@ rtl/core/arx_pkg.sv @@
// arx_pkg: shared sample and coefficient types and fixed-point constants
// for the ARX plant model step. No dependencies.
package arx_pkg;

    // sample and coefficient formats
    localparam int SAMPLE_W  = 16;   // Q4.12
    localparam int COEF_W    = 16;   // Q2.14
    localparam int DT_CFG_W  = 4;    // width of the dead time register
    localparam int FRAC_W    = 14;   // coefficient fraction bits
    localparam int CFG_DATA_W = 16;  // widest configuration register

    // rounding offset: half an output lsb in the Q.26 accumulator
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);

    // output saturation bounds
    localparam int Y_MAX = 32767;
    localparam int Y_MIN = -32768;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic [DT_CFG_W-1:0]        t_dead_time;

endpackage

@@ rtl/core/arx_cfg.sv @@
// arx_cfg: configuration register file (feedback coefs, drive coefs, dead time).
// Depends on arx_pkg.
module arx_cfg #(
    parameter int FEEDBACK_TAPS = 3,
    parameter int DRIVE_TAPS    = 3,
    parameter int CFG_IDX_W     = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [arx_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output arx_pkg::t_coef                o_fb_coef [FEEDBACK_TAPS],
    output arx_pkg::t_coef                o_dr_coef [DRIVE_TAPS],
    output arx_pkg::t_dead_time           o_dead_time
);
    import arx_pkg::*;

    // register index map: feedback first, then drive, dead time last
    localparam int DT_IDX = FEEDBACK_TAPS + DRIVE_TAPS;

    t_coef      r_fb_coef [FEEDBACK_TAPS];
    t_coef      r_dr_coef [DRIVE_TAPS];
    t_dead_time r_dead_time;

    // feedback coefficient registers
    for (genvar k = 0; k < FEEDBACK_TAPS; k++) begin : g_fb
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fb_coef[k] <= '0;
            end else if (i_cfg_we && (i_cfg_idx == CFG_IDX_W'(k))) begin
                r_fb_coef[k] <= t_coef'(i_cfg_wdata[COEF_W-1:0]);
            end
        end
        assign o_fb_coef[k] = r_fb_coef[k];
    end

    // drive coefficient registers
    for (genvar k = 0; k < DRIVE_TAPS; k++) begin : g_dr
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dr_coef[k] <= '0;
            end else if (i_cfg_we && (i_cfg_idx == CFG_IDX_W'(FEEDBACK_TAPS + k))) begin
                r_dr_coef[k] <= t_coef'(i_cfg_wdata[COEF_W-1:0]);
            end
        end
        assign o_dr_coef[k] = r_dr_coef[k];
    end

    // dead time register, resets to one sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_time <= t_dead_time'(1);
        end else if (i_cfg_we && (i_cfg_idx == CFG_IDX_W'(DT_IDX))) begin
            r_dead_time <= i_cfg_wdata[DT_CFG_W-1:0];
        end
    end

    assign o_dead_time = r_dead_time;

endmodule

@@ rtl/core/arx_mac.sv @@
// arx_mac: one difference-equation step, tap select, products, sum,
// round to nearest and saturate. Combinational. Depends on arx_pkg.
module arx_mac #(
    parameter int FEEDBACK_TAPS = 3,
    parameter int DRIVE_TAPS    = 3,
    parameter int MAX_DEAD_TIME = 8,
    parameter int DRIVE_DEPTH   = 11
) (
    input  arx_pkg::t_sample    i_drive_hist [DRIVE_DEPTH],
    input  arx_pkg::t_sample    i_y_hist     [FEEDBACK_TAPS],
    input  arx_pkg::t_sample    i_disturbance,
    input  arx_pkg::t_coef      i_fb_coef    [FEEDBACK_TAPS],
    input  arx_pkg::t_coef      i_dr_coef    [DRIVE_TAPS],
    input  arx_pkg::t_dead_time i_dead_time,
    output arx_pkg::t_sample    o_y
);
    import arx_pkg::*;

    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(FEEDBACK_TAPS + DRIVE_TAPS + 1) + 1;
    localparam int IDX_W  = (DRIVE_DEPTH > 1) ? $clog2(DRIVE_DEPTH) : 1;
    localparam int DT_W   = ($clog2(MAX_DEAD_TIME + 1) > DT_CFG_W) ?
                            $clog2(MAX_DEAD_TIME + 1) : DT_CFG_W;

    localparam logic signed [ACC_W-1:0] ACC_RND  = ACC_W'(ROUND_HALF);
    localparam logic signed [ACC_W-1:0] ACC_YMAX = ACC_W'(Y_MAX);
    localparam logic signed [ACC_W-1:0] ACC_YMIN = ACC_W'(Y_MIN);

    logic [DT_W-1:0]          w_dt_ext;
    logic [DT_W-1:0]          w_dt;
    logic [IDX_W-1:0]         w_tap_idx [DRIVE_TAPS];
    logic signed [PROD_W-1:0] w_dr_prod [DRIVE_TAPS];
    logic signed [PROD_W-1:0] w_fb_prod [FEEDBACK_TAPS];
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]  w_shift;

    // clamp dead time to 1 .. MAX_DEAD_TIME
    assign w_dt_ext = DT_W'(i_dead_time);

    always_comb begin
        priority if (w_dt_ext == '0) begin
            w_dt = DT_W'(1);
        end else if (w_dt_ext > DT_W'(MAX_DEAD_TIME)) begin
            w_dt = DT_W'(MAX_DEAD_TIME);
        end else begin
            w_dt = w_dt_ext;
        end
    end

    // variable taps of the drive delay line and the drive products
    for (genvar i = 0; i < DRIVE_TAPS; i++) begin : g_dr
        assign w_tap_idx[i] = IDX_W'(w_dt) + IDX_W'(i);
        assign w_dr_prod[i] = PROD_W'(i_dr_coef[i]) * PROD_W'(i_drive_hist[w_tap_idx[i]]);
    end

    // feedback products on the output history
    for (genvar i = 0; i < FEEDBACK_TAPS; i++) begin : g_fb
        assign w_fb_prod[i] = PROD_W'(i_fb_coef[i]) * PROD_W'(i_y_hist[i]);
    end

    // exact Q.26 sum, disturbance aligned to the product scale
    always_comb begin
        w_acc = ACC_W'(signed'({i_disturbance, {FRAC_W{1'b0}}}));
        for (int i = 0; i < DRIVE_TAPS; i++) begin
            w_acc = w_acc + ACC_W'(w_dr_prod[i]);
        end
        for (int i = 0; i < FEEDBACK_TAPS; i++) begin
            w_acc = w_acc - ACC_W'(w_fb_prod[i]);
        end
    end

    // round half up, then saturate to 16 bits
    assign w_rnd   = w_acc + ACC_RND;
    assign w_shift = w_rnd >>> FRAC_W;

    always_comb begin
        priority if (w_shift > ACC_YMAX) begin
            o_y = t_sample'(Y_MAX);
        end else if (w_shift < ACC_YMIN) begin
            o_y = t_sample'(Y_MIN);
        end else begin
            o_y = w_shift[SAMPLE_W-1:0];
        end
    end

endmodule

@@ rtl/core/arx_plant_model_step.sv @@
// arx_plant_model_step: ARX plant model, one output word per drive word.
// Each accepted word loads the input register; the input stage then advances into the
// result register through one pass of the multiply-sum-round logic, in which the
// output feedback loop closes, once that register is free; m_tready low holds both stages.
// Throughput: 1 word per cycle while m_tready is high.
// Reset (synchronous, active low): coefs 0, dead time 1, histories zeroed.
// Depends on arx_pkg, arx_cfg, arx_mac.
module arx_plant_model_step #(
    parameter int FEEDBACK_TAPS = 3,
    parameter int DRIVE_TAPS    = 3,
    parameter int MAX_DEAD_TIME = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [$clog2(FEEDBACK_TAPS + DRIVE_TAPS + 1)-1:0] i_cfg_idx,
    input  logic [arx_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,  // [15:0] drive_sample, [31:16] disturbance
    // output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata   // [15:0] plant_output
);
    import arx_pkg::*;

    localparam int CFG_IDX_W   = $clog2(FEEDBACK_TAPS + DRIVE_TAPS + 1);
    localparam int DRIVE_DEPTH = DRIVE_TAPS + MAX_DEAD_TIME;

    t_coef      w_fb_coef [FEEDBACK_TAPS];
    t_coef      w_dr_coef [DRIVE_TAPS];
    t_dead_time w_dead_time;

    logic     r_in_valid;
    logic     r_out_valid;
    t_sample  r_dist;
    t_sample  r_y;
    t_sample  r_drive_hist [DRIVE_DEPTH];
    t_sample  r_y_hist     [FEEDBACK_TAPS];
    t_sample  n_y;
    logic     w_adv;
    logic     w_s_acc;

    // configuration registers
    arx_cfg #(
        .FEEDBACK_TAPS (FEEDBACK_TAPS),
        .DRIVE_TAPS    (DRIVE_TAPS),
        .CFG_IDX_W     (CFG_IDX_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_fb_coef   (w_fb_coef),
        .o_dr_coef   (w_dr_coef),
        .o_dead_time (w_dead_time)
    );

    // handshake: the input stage moves on whenever the result register frees up
    assign w_adv    = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || w_adv;
    assign w_s_acc  = s_tvalid && s_tready;

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // drive delay line, shifted as each word is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DRIVE_DEPTH; i++) begin
                r_drive_hist[i] <= '0;
            end
        end else if (w_s_acc) begin
            for (int i = DRIVE_DEPTH - 1; i > 0; i--) begin
                r_drive_hist[i] <= r_drive_hist[i-1];
            end
            r_drive_hist[0] <= t_sample'(s_tdata[15:0]);
        end
    end

    // disturbance input register
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_dist <= t_sample'(s_tdata[31:16]);
        end
    end

    // difference equation
    arx_mac #(
        .FEEDBACK_TAPS (FEEDBACK_TAPS),
        .DRIVE_TAPS    (DRIVE_TAPS),
        .MAX_DEAD_TIME (MAX_DEAD_TIME),
        .DRIVE_DEPTH   (DRIVE_DEPTH)
    ) u_mac (
        .i_drive_hist  (r_drive_hist),
        .i_y_hist      (r_y_hist),
        .i_disturbance (r_dist),
        .i_fb_coef     (w_fb_coef),
        .i_dr_coef     (w_dr_coef),
        .i_dead_time   (w_dead_time),
        .o_y           (n_y)
    );

    // output history, shifted as each result is formed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FEEDBACK_TAPS; i++) begin
                r_y_hist[i] <= '0;
            end
        end else if (w_adv) begin
            for (int i = FEEDBACK_TAPS - 1; i > 0; i--) begin
                r_y_hist[i] <= r_y_hist[i-1];
            end
            r_y_hist[0] <= n_y;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_y <= n_y;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_y;

    // checks
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_tready) |-> !s_tready)
        else $error("input taken while both stages are full and stalled");

    a_result_matches_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (m_tvalid && (m_tdata == r_y_hist[0])))
        else $error("result word differs from newest output history entry");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> r_in_valid)
        else $error("accepted word lost from the input stage");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for arx_plant_model_step, predicts each output word
// from a local copy of the difference equation and compares words in order.
// Depends on arx_pkg and the arx_plant_model_step rtl.
module testbench;
    import arx_pkg::*;

    localparam int FB_TAPS      = 3;
    localparam int DRV_TAPS     = 3;
    localparam int MAX_DT       = 8;
    localparam int DRIVE_DEPTH  = DRV_TAPS + MAX_DT;
    localparam int DRAIN_CYCLES = 8;        // pipeline is two deep, leave margin
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int SEGMENTS     = 4;        // register settings per idling regime

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_FB_COEF_0,
        REG_FB_COEF_1,
        REG_FB_COEF_2,
        REG_DRV_COEF_0,
        REG_DRV_COEF_1,
        REG_DRV_COEF_2,
        REG_DEAD_TIME,
        REG_NONE
    } t_reg_idx;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] drive_sample, [31:16] disturbance
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // [15:0] plant_output

    arx_plant_model_step #(
        .FEEDBACK_TAPS (FB_TAPS),
        .DRIVE_TAPS    (DRV_TAPS),
        .MAX_DEAD_TIME (MAX_DT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // plant model state mirrored by the bench
    t_coef      fb_coef [FB_TAPS];
    t_coef      drv_coef[DRV_TAPS];
    t_dead_time dead_time_reg;
    t_sample    drive_line [DRIVE_DEPTH];
    t_sample    output_line[FB_TAPS];

    t_sample pending_outputs[$];
    int      error_count    = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** arx_plant_model_step: FAILED **");
            $finish;
        end
    end

    // output side backpressure
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each accepted output word with the oldest prediction
    always @(posedge i_clk) begin : check_output
        t_sample expected_y;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_outputs.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected output word %h at cycle %0d", m_tdata, cycle_count);
            end else begin
                expected_y = pending_outputs.pop_front();
                if (m_tdata !== expected_y) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("plant_output mismatch at cycle %0d: expected %0d, got %0d",
                                 cycle_count, expected_y, $signed(m_tdata));
                end
            end
        end
    end

    function automatic void reset_model();
        foreach (fb_coef[i])     fb_coef[i] = '0;
        foreach (drv_coef[i])    drv_coef[i] = '0;
        foreach (drive_line[i])  drive_line[i] = '0;
        foreach (output_line[i]) output_line[i] = '0;
        dead_time_reg = t_dead_time'(1);
    endfunction

    function automatic void apply_reg(input t_reg_idx idx, input logic [15:0] value);
        if (idx <= REG_FB_COEF_2)
            fb_coef[int'(idx) - int'(REG_FB_COEF_0)] = t_coef'(value);
        else if (idx <= REG_DRV_COEF_2)
            drv_coef[int'(idx) - int'(REG_DRV_COEF_0)] = t_coef'(value);
        else if (idx == REG_DEAD_TIME)
            dead_time_reg = value[DT_CFG_W-1:0];
        // unmapped index leaves everything as is
    endfunction

    // one step of the arx difference equation, rounded and saturated
    function automatic t_sample predict_plant_output(input t_sample drive, input t_sample disturb);
        longint acc;
        longint y;
        int     d;
        d = int'(dead_time_reg);
        if (d < 1) d = 1;
        if (d > MAX_DT) d = MAX_DT;
        for (int i = DRIVE_DEPTH - 1; i > 0; i--) drive_line[i] = drive_line[i-1];
        drive_line[0] = drive;
        acc = longint'(disturb) <<< FRAC_W;
        for (int i = 0; i < DRV_TAPS; i++)
            acc += longint'(drv_coef[i]) * longint'(drive_line[d+i]);
        for (int i = 0; i < FB_TAPS; i++)
            acc -= longint'(fb_coef[i]) * longint'(output_line[i]);
        // arithmetic shift floors, so a half lsb goes toward plus infinity
        y = (acc + longint'(ROUND_HALF)) >>> FRAC_W;
        if (y > longint'(Y_MAX)) y = longint'(Y_MAX);
        if (y < longint'(Y_MIN)) y = longint'(Y_MIN);
        for (int i = FB_TAPS - 1; i > 0; i--) output_line[i] = output_line[i-1];
        output_line[0] = t_sample'(y);
        return t_sample'(y);
    endfunction

    // send one input word, random gaps before it
    task automatic send_word(input t_sample drive, input t_sample disturb);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {disturb, drive};
        do @(posedge i_clk); while (!s_tready);
        pending_outputs.push_back(predict_plant_output(drive, disturb));
    endtask

    // stop sending and let every predicted word come out
    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        apply_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic clear_coefs();
        for (int i = 0; i < FB_TAPS + DRV_TAPS; i++)
            write_reg(t_reg_idx'(int'(REG_FB_COEF_0) + i), 16'h0000);
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3, 4: return t_sample'($urandom_range(8191)) - 16'sd4096;
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_sample rand_disturbance();
        if ($urandom_range(9) < 4)
            return '0;
        return rand_sample();
    endfunction

    function automatic logic [15:0] rand_coef(input bit wide, input int span);
        if (wide) begin
            case ($urandom_range(3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                default: return 16'($urandom);
            endcase
        end
        return 16'(int'($urandom_range(2 * span)) - span);
    endfunction

    // new random register setting, bench must be idle
    task automatic randomize_registers(input bit wide);
        for (int i = 0; i < FB_TAPS; i++)
            write_reg(t_reg_idx'(int'(REG_FB_COEF_0) + i), rand_coef(wide, 6000));
        for (int i = 0; i < DRV_TAPS; i++)
            write_reg(t_reg_idx'(int'(REG_DRV_COEF_0) + i), rand_coef(wide, 16384));
        // upper data bits are don't care for the dead time register
        write_reg(REG_DEAD_TIME, {12'($urandom), 4'($urandom_range(15))});
        if ($urandom_range(1))
            write_reg(REG_NONE, 16'($urandom));
    endtask

    // zero coefficients after reset: output is the disturbance alone
    task automatic test_power_up();
        send_word(16'sh7FFF, 16'sh7FFF);
        send_word(16'sh8000, 16'sh8000);
        send_word(16'sh0000, 16'sh0000);
        send_word(16'sh04D2, 16'shFFFF);
        wait_idle();
    endtask

    // exact half lsb rounds up for both signs
    task automatic test_rounding_tie();
        write_reg(REG_DRV_COEF_0, 16'h0001);
        send_word(16'sh2000, 16'sh0000);
        send_word(16'shE000, 16'sh0000);
        send_word(16'sh0000, 16'sh0000);
        wait_idle();
    endtask

    // accumulator far beyond the output range in both directions
    task automatic test_saturation();
        write_reg(REG_DRV_COEF_0, 16'h7FFF);
        write_reg(REG_DRV_COEF_1, 16'h7FFF);
        write_reg(REG_DRV_COEF_2, 16'h7FFF);
        write_reg(REG_FB_COEF_0,  16'h8000);
        repeat (3) send_word(16'sh7FFF, 16'sh7FFF);
        wait_idle();
        write_reg(REG_DRV_COEF_0, 16'h8000);
        write_reg(REG_DRV_COEF_1, 16'h8000);
        write_reg(REG_DRV_COEF_2, 16'h8000);
        write_reg(REG_FB_COEF_0,  16'h7FFF);
        write_reg(REG_FB_COEF_1,  16'h7FFF);
        write_reg(REG_FB_COEF_2,  16'h8000);
        repeat (3) send_word(16'sh7FFF, 16'sh8000);
        wait_idle();
    endtask

    // impulse through the dead time: zero acts as one, above the max clamps
    task automatic test_dead_time_limits();
        clear_coefs();
        write_reg(REG_DRV_COEF_0, 16'h4000);
        write_reg(REG_DEAD_TIME, 16'h0000);
        send_word(16'sh1000, 16'sh0000);
        send_word(16'sh0000, 16'sh0000);
        wait_idle();
        write_reg(REG_DEAD_TIME, 16'hFFFF);
        send_word(16'sh1000, 16'sh0000);
        repeat (8) send_word(16'sh0000, 16'sh0000);
        wait_idle();
    endtask

    // a write past the last register changes nothing
    task automatic test_unmapped_write();
        write_reg(REG_DEAD_TIME, 16'h0002);
        write_reg(REG_NONE, 16'hFFFF);
        send_word(16'sh0800, 16'sh0010);
        send_word(16'sh0000, 16'sh0000);
        wait_idle();
    endtask

    // random words under one idling regime, several register settings
    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_idle();
            randomize_registers(seg == 0);
            repeat (n_items / SEGMENTS) send_word(rand_sample(), rand_disturbance());
        end
        wait_idle();
    endtask

    // main sequence
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_FB_COEF_0;
        i_cfg_wdata = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        reset_model();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 18;
        recv_stall_pct = 78;
        test_power_up();
        test_rounding_tie();
        test_saturation();
        test_dead_time_limits();
        test_unmapped_write();

        test_random_traffic(18, 78, RANDOM_ITEMS / 3);
        test_random_traffic(78, 18, RANDOM_ITEMS / 3);
        test_random_traffic(0, 0, RANDOM_ITEMS / 3);

        if (error_count == 0)
            $display("** arx_plant_model_step: PASSED **");
        else
            $display("** arx_plant_model_step: FAILED **");
        $finish;
    end

endmodule

@@ arx_plant_model_step.f @@
rtl/core/arx_pkg.sv
rtl/core/arx_cfg.sv
rtl/core/arx_mac.sv
rtl/core/arx_plant_model_step.sv
bench/testbench.sv
